// ===== rtl/core/kuz_pkg.sv =====
// Kuznyechik package: substitution tables and GF(2^8) helpers.
package kuz_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned KeyW   = 64;

  typedef enum logic [1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } key_idx_e;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  localparam logic [7:0] PolyLow = 8'hC3;

  localparam logic [7:0] Sbox [256] = '{
    8'hfc,8'hee,8'hdd,8'h11,8'hcf,8'h6e,8'h31,8'h16,8'hfb,8'hc4,8'hfa,8'hda,8'h23,8'hc5,8'h04,8'h4d,
    8'he9,8'h77,8'hf0,8'hdb,8'h93,8'h2e,8'h99,8'hba,8'h17,8'h36,8'hf1,8'hbb,8'h14,8'hcd,8'h5f,8'hc1,
    8'hf9,8'h18,8'h65,8'h5a,8'he2,8'h5c,8'hef,8'h21,8'h81,8'h1c,8'h3c,8'h42,8'h8b,8'h01,8'h8e,8'h4f,
    8'h05,8'h84,8'h02,8'hae,8'he3,8'h6a,8'h8f,8'ha0,8'h06,8'h0b,8'hed,8'h98,8'h7f,8'hd4,8'hd3,8'h1f,
    8'heb,8'h34,8'h2c,8'h51,8'hea,8'hc8,8'h48,8'hab,8'hf2,8'h2a,8'h68,8'ha2,8'hfd,8'h3a,8'hce,8'hcc,
    8'hb5,8'h70,8'h0e,8'h56,8'h08,8'h0c,8'h76,8'h12,8'hbf,8'h72,8'h13,8'h47,8'h9c,8'hb7,8'h5d,8'h87,
    8'h15,8'ha1,8'h96,8'h29,8'h10,8'h7b,8'h9a,8'hc7,8'hf3,8'h91,8'h78,8'h6f,8'h9d,8'h9e,8'hb2,8'hb1,
    8'h32,8'h75,8'h19,8'h3d,8'hff,8'h35,8'h8a,8'h7e,8'h6d,8'h54,8'hc6,8'h80,8'hc3,8'hbd,8'h0d,8'h57,
    8'hdf,8'hf5,8'h24,8'ha9,8'h3e,8'ha8,8'h43,8'hc9,8'hd7,8'h79,8'hd6,8'hf6,8'h7c,8'h22,8'hb9,8'h03,
    8'he0,8'h0f,8'hec,8'hde,8'h7a,8'h94,8'hb0,8'hbc,8'hdc,8'he8,8'h28,8'h50,8'h4e,8'h33,8'h0a,8'h4a,
    8'ha7,8'h97,8'h60,8'h73,8'h1e,8'h00,8'h62,8'h44,8'h1a,8'hb8,8'h38,8'h82,8'h64,8'h9f,8'h26,8'h41,
    8'had,8'h45,8'h46,8'h92,8'h27,8'h5e,8'h55,8'h2f,8'h8c,8'ha3,8'ha5,8'h7d,8'h69,8'hd5,8'h95,8'h3b,
    8'h07,8'h58,8'hb3,8'h40,8'h86,8'hac,8'h1d,8'hf7,8'h30,8'h37,8'h6b,8'he4,8'h88,8'hd9,8'he7,8'h89,
    8'he1,8'h1b,8'h83,8'h49,8'h4c,8'h3f,8'hf8,8'hfe,8'h8d,8'h53,8'haa,8'h90,8'hca,8'hd8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'ha4,8'h2d,8'h2b,8'h09,8'h5b,8'hcb,8'h9b,8'h25,8'hd0,8'hbe,8'he5,8'h6c,8'h52,
    8'h59,8'ha6,8'h74,8'hd2,8'he6,8'hf4,8'hb4,8'hc0,8'hd1,8'h66,8'haf,8'hc2,8'h39,8'h4b,8'h63,8'hb6
  };

  localparam logic [7:0] Lcoef [16] = '{
    8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
    8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
  };

  // Inverse substitution by search over the constant table.
  function automatic logic [7:0] sbox_inv(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (Sbox[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  // Multiply by a constant coefficient in GF(2^8) mod 0x1C3.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? PolyLow : 8'h00);
    end
    return r;
  endfunction

  // Linear combination of all sixteen bytes.
  function automatic logic [7:0] lin(input logic [BlockW-1:0] a);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 16; i++) r = r ^ gf_mul(Lcoef[i], a[8*i +: 8]);
    return r;
  endfunction

  typedef struct packed {
    logic start;
    logic inv;
  } lunit_ctl_t;

endpackage

// ===== rtl/core/kuz_lunit.sv =====
// Serial L transform: one LFSR byte step per cycle, sixteen steps.
module kuz_lunit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kuz_pkg::lunit_ctl_t        ctl_i,
  input  logic [kuz_pkg::BlockW-1:0] data_i,
  output logic [kuz_pkg::BlockW-1:0] data_o,
  output logic                       done_o
);
  import kuz_pkg::*;

  logic [BlockW-1:0] sh_q, sh_d;
  logic [3:0]        cnt_q;
  logic              busy_q, inv_q;
  logic [BlockW-1:0] rot;

  // Form one forward or inverse step.
  always_comb begin
    rot = {sh_q[7:0], sh_q[BlockW-1:8]};
    if (inv_q) begin
      rot = {sh_q[BlockW-9:0], sh_q[BlockW-1 -: 8]};
      sh_d = {rot[BlockW-1:8], lin(rot)};
    end else begin
      sh_d = {lin(sh_q), sh_q[BlockW-1:8]};
    end
  end

  // Advance the shift register while busy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      inv_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        inv_q  <= ctl_i.inv;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) sh_q <= data_i;
    else if (busy_q) sh_q <= sh_d;
  end

  assign data_o = sh_q;
endmodule

// ===== rtl/core/kuznyechik_block_cipher.sv =====
// Kuznyechik cipher top level: key expansion, round sequencer and stream ports.
// Usage:
//  - Write key words 0..3 through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
//  - Send blocks on s_axis: tdata = {block_high, block_low}, tuser = command
//    (0 encrypt, 1 decrypt). Results leave on m_axis as {result_high, result_low}.
//  - Each round's L transform runs byte-serially in a shared unit: each round
//    has a start state, then waits for the unit to finish. The next input beat
//    is taken only after the result beat has left.
//  - The first block after reset or a key write first expands the round keys:
//    32 Feistel rounds, each needing two L passes (constant and data).
//  - One block at a time; s_axis_tready is low while a block is in work or
//    while the result waits. A stalled receiver holds the result register.
//  - Reset clears the key words and marks the round keys stale.
module kuznyechik_block_cipher #(
  parameter int unsigned ROUND_KEY_COUNT = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_low [63:0], block_high [127:64]
  input  logic         s_axis_tuser,  // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // result_low [63:0], result_high [127:64]
);
  import kuz_pkg::*;

  localparam int unsigned RkW = $clog2(ROUND_KEY_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE, ST_KCONST, ST_KWAIT_C, ST_KDATA, ST_KWAIT_D,
    ST_EROUND, ST_EWAIT, ST_DSTART, ST_DWAIT, ST_OUT
  } state_e;

  state_e            state_q;
  logic [63:0]       key_q [4];
  logic              ready_keys_q;
  logic [BlockW-1:0] rk_q [ROUND_KEY_COUNT];
  logic [BlockW-1:0] a_q, a1_q, a0_q, c_q;
  logic              cmd_q;
  logic [RkW-1:0]    rnd_q;
  logic [5:0]        kn_q;
  logic [BlockW-1:0] res_q;
  logic              res_v_q;
  lunit_ctl_t        lctl;
  logic [BlockW-1:0] l_in, l_out, sx;
  logic              l_done;

  kuz_lunit u_l (
    .clk_i, .rst_ni, .ctl_i(lctl), .data_i(l_in), .data_o(l_out), .done_o(l_done)
  );

  // Substitute, inverse-substitute helpers over the current operand.
  logic [BlockW-1:0] sin, sx_in, isx;
  always_comb begin
    sin = a1_q ^ c_q;
    if (state_q == ST_EROUND) sin = a_q ^ rk_q[rnd_q];
    for (int i = 0; i < 16; i++) sx[8*i +: 8] = Sbox[sin[8*i +: 8]];
    sx_in = l_out;
    for (int i = 0; i < 16; i++) isx[8*i +: 8] = sbox_inv(sx_in[8*i +: 8]);
  end

  // Drive the L unit start and operand.
  always_comb begin
    lctl.start = 1'b0;
    lctl.inv   = 1'b0;
    l_in       = sx;
    unique case (state_q)
      ST_KCONST: begin
        lctl.start = 1'b1;
        l_in = {{(BlockW-8){1'b0}}, 2'b00, kn_q};
      end
      ST_KDATA, ST_EROUND: lctl.start = 1'b1;
      ST_DSTART: begin
        lctl.start = 1'b1;
        lctl.inv = 1'b1;
        l_in = a_q;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !res_v_q;
  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata  = res_q;

  // Sequence key expansion and the cipher rounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ready_keys_q <= 1'b0;
      res_v_q      <= 1'b0;
      rnd_q        <= '0;
      kn_q         <= '0;
      cmd_q        <= 1'b0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        key_q[cfg_idx_i] <= cfg_data_i;
        ready_keys_q     <= 1'b0;
      end
      if (res_v_q && m_axis_tready) res_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          a_q   <= s_axis_tdata;
          cmd_q <= s_axis_tuser;
          if (!ready_keys_q) begin
            rk_q[0] <= {key_q[KEY_WORD1], key_q[KEY_WORD0]};
            rk_q[1] <= {key_q[KEY_WORD3], key_q[KEY_WORD2]};
            a1_q    <= {key_q[KEY_WORD1], key_q[KEY_WORD0]};
            a0_q    <= {key_q[KEY_WORD3], key_q[KEY_WORD2]};
            kn_q    <= 6'd1;
            state_q <= ST_KCONST;
          end else if (s_axis_tuser == CMD_DECRYPT) begin
            a_q     <= s_axis_tdata ^ rk_q[ROUND_KEY_COUNT-1];
            rnd_q   <= RkW'(ROUND_KEY_COUNT-2);
            state_q <= ST_DSTART;
          end else begin
            rnd_q   <= '0;
            state_q <= ST_EROUND;
          end
        end
        ST_KCONST: state_q <= ST_KWAIT_C;
        ST_KWAIT_C: if (l_done) begin
          c_q     <= l_out;
          state_q <= ST_KDATA;
        end
        ST_KDATA: state_q <= ST_KWAIT_D;
        ST_KWAIT_D: if (l_done) begin
          a1_q <= l_out ^ a0_q;
          a0_q <= a1_q;
          if (kn_q[2:0] == 3'd0) begin
            rk_q[kn_q[5:2]]       <= l_out ^ a0_q;
            rk_q[kn_q[5:2] + 4'd1] <= a1_q;
          end
          if (kn_q == 6'd32) begin
            ready_keys_q <= 1'b1;
            if (cmd_q == CMD_DECRYPT) begin
              // The last round key is being stored this cycle: take it from a1_q
              a_q     <= a_q ^ a1_q;
              rnd_q   <= RkW'(ROUND_KEY_COUNT-2);
              state_q <= ST_DSTART;
            end else begin
              rnd_q   <= '0;
              state_q <= ST_EROUND;
            end
          end else begin
            kn_q    <= kn_q + 6'd1;
            state_q <= ST_KCONST;
          end
        end
        ST_EROUND: state_q <= ST_EWAIT;
        ST_EWAIT: if (l_done) begin
          if (rnd_q == RkW'(ROUND_KEY_COUNT-2)) begin
            res_q   <= l_out ^ rk_q[ROUND_KEY_COUNT-1];
            res_v_q <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            a_q     <= l_out;
            rnd_q   <= rnd_q + RkW'(1);
            state_q <= ST_EROUND;
          end
        end
        ST_DSTART: state_q <= ST_DWAIT;
        ST_DWAIT: if (l_done) begin
          a_q <= isx ^ rk_q[rnd_q];
          if (rnd_q == '0) begin
            res_q   <= isx ^ rk_q[0];
            res_v_q <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            rnd_q   <= rnd_q - RkW'(1);
            state_q <= ST_DSTART;
          end
        end
        ST_OUT: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A result is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !m_axis_tready |=> res_v_q && $stable(res_q))
    else $error("result lost");
  // Rounds start only with expanded keys.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EROUND || state_q == ST_DSTART) |-> ready_keys_q)
    else $error("round without keys");
  // Input is taken only when idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE && !m_axis_tvalid)
    else $error("ready while busy");
endmodule

// ===== tb/kuznyechik_block_cipher_tb.sv =====
// Testbench for the Kuznyechik block engine: stimulus, round-key predictor and result check.
module kuznyechik_block_cipher_tb;
  import kuz_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } block_pair_t;

  typedef struct {
    cmd_e        cmd;
    logic [63:0] lo;
    logic [63:0] hi;
  } block_item_t;

  localparam int RandomItems = 900;
  localparam int KeyPhases   = 8;

  localparam logic [7:0] PiTab [256] = '{
    8'hfc,8'hee,8'hdd,8'h11,8'hcf,8'h6e,8'h31,8'h16,8'hfb,8'hc4,8'hfa,8'hda,8'h23,8'hc5,8'h04,8'h4d,
    8'he9,8'h77,8'hf0,8'hdb,8'h93,8'h2e,8'h99,8'hba,8'h17,8'h36,8'hf1,8'hbb,8'h14,8'hcd,8'h5f,8'hc1,
    8'hf9,8'h18,8'h65,8'h5a,8'he2,8'h5c,8'hef,8'h21,8'h81,8'h1c,8'h3c,8'h42,8'h8b,8'h01,8'h8e,8'h4f,
    8'h05,8'h84,8'h02,8'hae,8'he3,8'h6a,8'h8f,8'ha0,8'h06,8'h0b,8'hed,8'h98,8'h7f,8'hd4,8'hd3,8'h1f,
    8'heb,8'h34,8'h2c,8'h51,8'hea,8'hc8,8'h48,8'hab,8'hf2,8'h2a,8'h68,8'ha2,8'hfd,8'h3a,8'hce,8'hcc,
    8'hb5,8'h70,8'h0e,8'h56,8'h08,8'h0c,8'h76,8'h12,8'hbf,8'h72,8'h13,8'h47,8'h9c,8'hb7,8'h5d,8'h87,
    8'h15,8'ha1,8'h96,8'h29,8'h10,8'h7b,8'h9a,8'hc7,8'hf3,8'h91,8'h78,8'h6f,8'h9d,8'h9e,8'hb2,8'hb1,
    8'h32,8'h75,8'h19,8'h3d,8'hff,8'h35,8'h8a,8'h7e,8'h6d,8'h54,8'hc6,8'h80,8'hc3,8'hbd,8'h0d,8'h57,
    8'hdf,8'hf5,8'h24,8'ha9,8'h3e,8'ha8,8'h43,8'hc9,8'hd7,8'h79,8'hd6,8'hf6,8'h7c,8'h22,8'hb9,8'h03,
    8'he0,8'h0f,8'hec,8'hde,8'h7a,8'h94,8'hb0,8'hbc,8'hdc,8'he8,8'h28,8'h50,8'h4e,8'h33,8'h0a,8'h4a,
    8'ha7,8'h97,8'h60,8'h73,8'h1e,8'h00,8'h62,8'h44,8'h1a,8'hb8,8'h38,8'h82,8'h64,8'h9f,8'h26,8'h41,
    8'had,8'h45,8'h46,8'h92,8'h27,8'h5e,8'h55,8'h2f,8'h8c,8'ha3,8'ha5,8'h7d,8'h69,8'hd5,8'h95,8'h3b,
    8'h07,8'h58,8'hb3,8'h40,8'h86,8'hac,8'h1d,8'hf7,8'h30,8'h37,8'h6b,8'he4,8'h88,8'hd9,8'he7,8'h89,
    8'he1,8'h1b,8'h83,8'h49,8'h4c,8'h3f,8'hf8,8'hfe,8'h8d,8'h53,8'haa,8'h90,8'hca,8'hd8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'ha4,8'h2d,8'h2b,8'h09,8'h5b,8'hcb,8'h9b,8'h25,8'hd0,8'hbe,8'he5,8'h6c,8'h52,
    8'h59,8'ha6,8'h74,8'hd2,8'he6,8'hf4,8'hb4,8'hc0,8'hd1,8'h66,8'haf,8'hc2,8'h39,8'h4b,8'h63,8'hb6
  };

  localparam logic [7:0] MixWeight [16] = '{
    8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
    8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  key_idx_e     cfg_idx_i = KEY_WORD0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // block_low [63:0], block_high [127:64]
  logic         s_axis_tuser = 1'b0;  // command
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;  // result_low [63:0], result_high [127:64]

  kuznyechik_block_cipher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4ns clk_i = ~clk_i;

  // Predictor state: key words, expanded round keys, stale flag
  logic [63:0]  key_words [4];
  logic [127:0] round_keys [10];
  logic         round_keys_valid;
  logic [7:0]   pi_inverse [256];

  block_pair_t  pending_results [$];
  int           fail_count;
  int           results_seen;

  // GF(2^8) product modulo x^8 + x^7 + x^6 + x + 1
  function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'hC3 : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] mix_byte(logic [127:0] a);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++) acc ^= gf_product(MixWeight[i], a[8*i +: 8]);
    return acc;
  endfunction

  // Sixteen LFSR steps: new byte enters at the top
  function automatic logic [127:0] mix_forward(logic [127:0] a);
    for (int t = 0; t < 16; t++) a = {mix_byte(a), a[127:8]};
    return a;
  endfunction

  function automatic logic [127:0] mix_backward(logic [127:0] a);
    for (int t = 0; t < 16; t++) begin
      a = {a[119:0], a[127:120]};
      a[7:0] = mix_byte(a);
    end
    return a;
  endfunction

  function automatic logic [127:0] substitute(logic [127:0] a, logic inv);
    for (int i = 0; i < 16; i++) a[8*i +: 8] = inv ? pi_inverse[a[8*i +: 8]] : PiTab[a[8*i +: 8]];
    return a;
  endfunction

  function automatic logic [127:0] cipher_round(logic [127:0] a, logic [127:0] k);
    return mix_forward(substitute(a ^ k, 1'b0));
  endfunction

  // Key schedule: four groups of eight Feistel rounds
  task automatic expand_round_keys();
    logic [127:0] left, right, held, rc;
    round_keys[0] = {key_words[1], key_words[0]};
    round_keys[1] = {key_words[3], key_words[2]};
    for (int g = 1; g <= 4; g++) begin
      left  = round_keys[2*g-2];
      right = round_keys[2*g-1];
      for (int j = 0; j < 8; j++) begin
        rc    = mix_forward(128'(8 * (g - 1) + j + 1));
        held  = left;
        left  = cipher_round(left, rc) ^ right;
        right = held;
      end
      round_keys[2*g]   = left;
      round_keys[2*g+1] = right;
    end
    round_keys_valid = 1'b1;
  endtask

  task automatic predict_block(input block_item_t item, output block_pair_t res);
    logic [127:0] a;
    if (!round_keys_valid) expand_round_keys();
    a = {item.hi, item.lo};
    if (item.cmd == CMD_ENCRYPT) begin
      for (int r = 0; r < 9; r++) a = cipher_round(a, round_keys[r]);
      a ^= round_keys[9];
    end else begin
      a ^= round_keys[9];
      for (int r = 8; r >= 0; r--) a = substitute(mix_backward(a), 1'b1) ^ round_keys[r];
    end
    res.lo = a[63:0];
    res.hi = a[127:64];
  endtask

  // Register write while idle; invalidates the round keys
  task automatic write_key(key_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    key_words[idx]   = value;
    round_keys_valid = 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Offer one beat, hold it until accepted, then record the expected result
  task automatic send_block(block_item_t item, int gap, output block_pair_t res);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {item.hi, item.lo};
    s_axis_tuser  <= item.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_block(item, res);
    pending_results.push_back(res);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Stimulus
  initial begin
    block_item_t directed_rows [$];
    block_item_t item;
    block_pair_t res, last_res;
    int per_phase;
    for (int i = 0; i < 256; i++) pi_inverse[PiTab[i]] = 8'(i);
    foreach (key_words[i]) key_words[i] = '0;
    foreach (round_keys[i]) round_keys[i] = '0;
    round_keys_valid = 1'b0;
    fail_count   = 0;
    results_seen = 0;
    last_res     = '{lo: '0, hi: '0};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows under the reset key: extremes and both commands
    directed_rows = '{
      '{CMD_ENCRYPT, 64'h0, 64'h0},
      '{CMD_DECRYPT, 64'h0, 64'h0},
      '{CMD_ENCRYPT, '1, '1},
      '{CMD_DECRYPT, '1, '1},
      '{CMD_ENCRYPT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
      '{CMD_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
      '{CMD_ENCRYPT, 64'h1, 64'h0},
      '{CMD_ENCRYPT, 64'h0, 64'h8000_0000_0000_0000},
      '{CMD_DECRYPT, 64'h8000_0000_0000_0000, 64'h1},
      '{CMD_ENCRYPT, 64'h7766_5500_1122_3344, 64'h8899_AABB_CCDD_EEFF}
    };
    foreach (directed_rows[i]) send_block(directed_rows[i], pick_gap(), res);
    drain_results();

    // Key phases: extremes first, then random keys, some partial rewrites
    per_phase = RandomItems / KeyPhases;
    for (int ph = 0; ph < KeyPhases; ph++) begin
      case (ph)
        0: for (int w = 0; w < 4; w++) write_key(key_idx_e'(w), '1);
        1: for (int w = 0; w < 4; w++) write_key(key_idx_e'(w), '0);
        2: for (int w = 0; w < 4; w++)
             write_key(key_idx_e'(w), w[0] ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555);
        3: write_key(KEY_WORD2, rand64());
        default: for (int w = 0; w < 4; w++) write_key(key_idx_e'(w), rand64());
      endcase
      for (int n = 0; n < per_phase; n++) begin
        // Reuse the previous result as the block (random command), otherwise random blocks
        if (n > 0 && $urandom_range(0, 3) == 0) begin
          item.cmd = cmd_e'($urandom_range(0, 1));
          item.lo  = last_res.lo;
          item.hi  = last_res.hi;
        end else begin
          item.cmd = cmd_e'($urandom_range(0, 1));
          item.lo  = rand64();
          item.hi  = rand64();
        end
        send_block(item, (ph % 3 == 1) ? 0 : pick_gap(), res);
        last_res = res;
      end
      drain_results();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result sink: random stalls, stall-free stretches, one long hold-off
  initial begin
    int len;
    bit long_hold_done;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (3000) @(negedge clk_i);
      end else if ($urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(50, 400)) @(negedge clk_i);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          m_axis_tready <= 1'b0;
          repeat (len - 1) @(negedge clk_i);
          @(negedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    block_pair_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation: %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== exp_res.lo) begin
          $error("result_low: expected %h actual %h", exp_res.lo, m_axis_tdata[63:0]);
          fail_count++;
        end
        if (m_axis_tdata[127:64] !== exp_res.hi) begin
          $error("result_high: expected %h actual %h", exp_res.hi, m_axis_tdata[127:64]);
          fail_count++;
        end
      end
    end
  end

  // Guard against a hung run
  initial begin
    #12ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
